[sv/lsp_pkg.sv]
// Shared types, constants and helper functions of the LED strip pattern engine.
// Used by the serial divider and the core; depends on nothing.
package lsp_pkg;

  localparam int MAX_PIXELS = 64;
  localparam int PIX_W      = $clog2(MAX_PIXELS);
  localparam int CNT_W      = 7;
  localparam int DIV_N_W    = 24;
  localparam int DIV_D_W    = 16;
  localparam int DIV_CNT_W  = $clog2(DIV_N_W + 1);

  // Register indexes on the configuration channel
  localparam logic [2:0] REG_MODE      = 3'd0;
  localparam logic [2:0] REG_INTERVAL  = 3'd1;
  localparam logic [2:0] REG_COLOUR1   = 3'd2;
  localparam logic [2:0] REG_COLOUR2   = 3'd3;
  localparam logic [2:0] REG_FADESTEPS = 3'd4;
  localparam logic [2:0] REG_STARTREV  = 3'd5;
  localparam logic [2:0] REG_PIXCOUNT  = 3'd6;

  // Pattern modes
  localparam logic [2:0] MODE_NONE    = 3'd0;
  localparam logic [2:0] MODE_RAINBOW = 3'd1;
  localparam logic [2:0] MODE_THEATER = 3'd2;
  localparam logic [2:0] MODE_WIPE    = 3'd3;
  localparam logic [2:0] MODE_SCANNER = 3'd4;
  localparam logic [2:0] MODE_FADE    = 3'd5;

  // Item kinds
  localparam logic KIND_TICK    = 1'b0;
  localparam logic KIND_REVERSE = 1'b1;

  localparam logic [15:0] RAINBOW_STEPS = 16'd255;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EMIT,
    S_RB_START,
    S_RB_WAIT,
    S_TC_START,
    S_TC_PIX,
    S_SC_RD,
    S_SC_WAIT,
    S_PROD_A,
    S_PROD_B,
    S_FD_WAIT,
    S_ADV
  } state_t;

  typedef struct packed {
    logic               start;
    logic [DIV_N_W-1:0] dividend;
    logic [DIV_D_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [DIV_N_W-1:0] quotient;
    logic [DIV_D_W-1:0] remainder;
  } div_rsp_t;

  // Colour wheel: red to green to blue and back over 256 positions
  function automatic logic [23:0] wheel(input logic [7:0] pos);
    logic [7:0] p;
    logic [7:0] q;
    p = 8'd255 - pos;
    if (p < 8'd85) begin
      q = p * 8'd3;
      wheel = {8'd255 - q, 8'd0, q};
    end else if (p < 8'd170) begin
      q = (p - 8'd85) * 8'd3;
      wheel = {8'd0, q, 8'd255 - q};
    end else begin
      q = (p - 8'd170) * 8'd3;
      wheel = {q, 8'd255 - q, 8'd0};
    end
  endfunction

  // Halve each channel
  function automatic logic [23:0] dim(input logic [23:0] c);
    dim = (c >> 1) & 24'h7F7F7F;
  endfunction

  // Remainder by three: four leaves one over three, so sum the base-4 digits and fold
  function automatic logic [1:0] mod3(input logic [15:0] v);
    logic [4:0] s;
    logic [3:0] t;
    logic [2:0] u;
    s = '0;
    for (int i = 0; i < 8; i++) begin
      s = s + 5'(v[2*i +: 2]);
    end
    t = 4'(s[4:2]) + 4'(s[1:0]);
    u = 3'(t[3:2]) + 3'(t[1:0]);
    mod3 = (u >= 3'd3) ? 2'(u - 3'd3) : u[1:0];
  endfunction

endpackage

[sv/lsp_if.sv]
// Handshake interfaces of the LED strip pattern engine: input items, results
// and configuration writes. Depends on nothing.
interface lsp_item_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [31:0] now_ms;
  modport source (output valid, kind, now_ms, input ready);
  modport sink (input valid, kind, now_ms, output ready);
endinterface

interface lsp_result_if;
  logic       valid;
  logic       ready;
  logic       updated;
  logic [5:0] pixel;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic       last;
  modport source (output valid, updated, pixel, red, green, blue, last, input ready);
  modport sink (input valid, updated, pixel, red, green, blue, last, output ready);
endinterface

interface lsp_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[sv/lsp_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module lsp_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[sv/lsp_div.sv]
// Restoring serial divider, one quotient bit per cycle.
// Depends on lsp_pkg for the request and response structs.
module lsp_div (
  input  logic              clk,
  input  logic              rst,
  input  lsp_pkg::div_req_t req,
  output lsp_pkg::div_rsp_t rsp
);

  logic [lsp_pkg::DIV_N_W-1:0]   q;
  logic [lsp_pkg::DIV_D_W-1:0]   r;
  logic [lsp_pkg::DIV_D_W-1:0]   d;
  logic [lsp_pkg::DIV_CNT_W-1:0] cnt;
  logic                          done;
  logic [lsp_pkg::DIV_D_W:0]     rt;
  logic                          ge;

  // Trial subtract of the shifted partial remainder
  always_comb begin
    rt = {r, q[lsp_pkg::DIV_N_W-1]};
    ge = rt >= {1'b0, d};
  end

  // Control: bit counter and done pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= (cnt == lsp_pkg::DIV_CNT_W'(1));
      if (req.start) begin
        cnt <= lsp_pkg::DIV_CNT_W'(lsp_pkg::DIV_N_W);
      end else if (cnt != '0) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

  // Datapath: shift quotient in, keep remainder
  always_ff @(posedge clk) begin
    if (req.start) begin
      q <= req.dividend;
      r <= '0;
      d <= req.divisor;
    end else if (cnt != '0) begin
      r <= ge ? lsp_pkg::DIV_D_W'(rt - {1'b0, d}) : rt[lsp_pkg::DIV_D_W-1:0];
      q <= {q[lsp_pkg::DIV_N_W-2:0], ge};
    end
  end

  assign rsp.done      = done;
  assign rsp.quotient  = q;
  assign rsp.remainder = r;

endmodule

[sv/led_strip_pattern_generator_core.sv]
// Channel   Dir  Payload                                    Accepted when
// item      in   kind, now_ms                               valid & ready
// result    out  updated, pixel, red, green, blue, last     valid & ready
// cfg       in   index, data                                valid & ready (ready while idle)
//
// One item at a time. A reverse request, an early tick or an idle mode gives one
// result. Per pixel, rainbow runs one serial division through the shared divider
// and scanner a trail RAM read-modify-write; theater first works out its phase,
// and fade first runs three divisions, one per colour channel.
// Reset is synchronous and clears the trail valid bits at once; no clearing pass.
// A stalled result holds the sequencer in place; nothing is lost.
// Depends on lsp_pkg, lsp_if, lsp_div and lsp_ram.
module led_strip_pattern_generator_core (
  input logic                clk,
  input logic                rst,
  lsp_item_if.sink           item,
  lsp_result_if.source       result,
  lsp_cfg_if.sink            cfg
);

  // Configuration
  logic [2:0]  mode;
  logic [31:0] interval;
  logic [23:0] c1;
  logic [23:0] c2;
  logic [15:0] fsteps;
  logic        start_rev;
  logic [6:0]  pcount;

  // Pattern state
  logic [31:0] last_ms;
  logic [15:0] step;
  logic        going_rev;
  logic [lsp_pkg::MAX_PIXELS-1:0] trail_valid;

  // Sequencer
  lsp_pkg::state_t state, state_next;
  logic [lsp_pkg::PIX_W-1:0] pix;
  logic [1:0]  phase;
  logic [23:0] col;
  logic        upd;
  logic        single;
  logic        adv;
  logic [1:0]  ch;
  logic [23:0] acc;
  logic        rd_ok;

  // Output register
  logic        out_valid;
  logic        out_upd;
  logic [5:0]  out_pix;
  logic [23:0] out_rgb;
  logic        out_last;

  // Derived values
  logic [lsp_pkg::CNT_W-1:0] n;
  logic [15:0] tot;
  logic [15:0] fade_k;
  logic [15:0] adv_step;
  logic [15:0] rev_base;
  logic        accept;
  logic        due;
  logic        out_free;
  logic        last_pix;
  logic        last_e;
  logic [7:0]  ca;
  logic [7:0]  cb;
  logic        hit;
  logic [23:0] trail_rd;
  logic [23:0] trail_val;
  logic [23:0] sc_col;
  logic        trail_we;
  logic        trail_re;
  lsp_pkg::div_req_t div_req;
  lsp_pkg::div_rsp_t div_rsp;

  // Effective pixel count and step count of the active mode
  always_comb begin
    if (pcount == '0) begin
      n = lsp_pkg::CNT_W'(1);
    end else if (pcount > lsp_pkg::CNT_W'(lsp_pkg::MAX_PIXELS)) begin
      n = lsp_pkg::CNT_W'(lsp_pkg::MAX_PIXELS);
    end else begin
      n = pcount;
    end
    case (mode)
      lsp_pkg::MODE_RAINBOW: tot = lsp_pkg::RAINBOW_STEPS;
      lsp_pkg::MODE_THEATER: tot = 16'(n);
      lsp_pkg::MODE_WIPE:    tot = 16'(n);
      lsp_pkg::MODE_SCANNER: tot = 16'((n - 1'b1) << 1);
      lsp_pkg::MODE_FADE:    tot = (fsteps == '0) ? 16'd1 : fsteps;
      default:               tot = 16'd1;
    endcase
    fade_k = (step > tot) ? tot : step;
  end

  // Next step index: forward wraps at the count, reverse skips zero
  always_comb begin
    rev_base = (step != '0) ? step - 1'b1 : step;
    if (!going_rev) begin
      adv_step = ((step + 1'b1) == tot) ? 16'd0 : step + 1'b1;
    end else begin
      adv_step = (rev_base == '0) ? tot - 1'b1 : rev_base;
    end
  end

  // Handshake and per-pixel decisions
  always_comb begin
    accept   = item.valid && item.ready;
    due      = (item.now_ms - last_ms) >= interval;
    out_free = !out_valid || result.ready;
    last_pix = ({1'b0, pix} == n - 1'b1);
    last_e   = single || last_pix;
    case (ch)
      2'd0:    begin ca = c1[23:16]; cb = c2[23:16]; end
      2'd1:    begin ca = c1[15:8];  cb = c2[15:8];  end
      default: begin ca = c1[7:0];   cb = c2[7:0];   end
    endcase
    hit       = (16'(pix) == step) || ((step <= tot) && (16'(pix) == tot - step));
    trail_val = rd_ok ? trail_rd : 24'd0;
    sc_col    = hit ? c1 : lsp_pkg::dim(trail_val);
  end

  // Next state and sequencer outputs
  always_comb begin
    state_next       = state;
    div_req.start    = 1'b0;
    div_req.dividend = '0;
    div_req.divisor  = '0;
    trail_we         = 1'b0;
    trail_re         = 1'b0;
    case (state)
      lsp_pkg::S_IDLE: begin
        if (accept) begin
          if (item.kind == lsp_pkg::KIND_REVERSE || !due) begin
            state_next = lsp_pkg::S_EMIT;
          end else begin
            case (mode)
              lsp_pkg::MODE_RAINBOW: state_next = lsp_pkg::S_RB_START;
              lsp_pkg::MODE_THEATER: state_next = lsp_pkg::S_TC_START;
              lsp_pkg::MODE_SCANNER: state_next = lsp_pkg::S_SC_RD;
              lsp_pkg::MODE_FADE:    state_next = lsp_pkg::S_PROD_A;
              default:               state_next = lsp_pkg::S_EMIT;
            endcase
          end
        end
      end
      lsp_pkg::S_EMIT: begin
        if (out_free) begin
          if (last_e) begin
            state_next = adv ? lsp_pkg::S_ADV : lsp_pkg::S_IDLE;
          end else begin
            case (mode)
              lsp_pkg::MODE_RAINBOW: state_next = lsp_pkg::S_RB_START;
              lsp_pkg::MODE_THEATER: state_next = lsp_pkg::S_TC_PIX;
              lsp_pkg::MODE_SCANNER: state_next = lsp_pkg::S_SC_RD;
              default:               state_next = lsp_pkg::S_EMIT;
            endcase
          end
        end
      end
      lsp_pkg::S_RB_START: begin
        div_req.start    = 1'b1;
        div_req.dividend = lsp_pkg::DIV_N_W'({pix, 8'd0});
        div_req.divisor  = lsp_pkg::DIV_D_W'(n);
        state_next       = lsp_pkg::S_RB_WAIT;
      end
      lsp_pkg::S_RB_WAIT: begin
        if (div_rsp.done) begin
          state_next = lsp_pkg::S_EMIT;
        end
      end
      lsp_pkg::S_TC_START: state_next = lsp_pkg::S_TC_PIX;
      lsp_pkg::S_TC_PIX: state_next = lsp_pkg::S_EMIT;
      lsp_pkg::S_SC_RD: begin
        trail_re   = 1'b1;
        state_next = lsp_pkg::S_SC_WAIT;
      end
      lsp_pkg::S_SC_WAIT: begin
        trail_we   = 1'b1;
        state_next = lsp_pkg::S_EMIT;
      end
      lsp_pkg::S_PROD_A: state_next = lsp_pkg::S_PROD_B;
      lsp_pkg::S_PROD_B: begin
        div_req.start    = 1'b1;
        div_req.dividend = acc + 24'(cb) * 24'(fade_k);
        div_req.divisor  = tot;
        state_next       = lsp_pkg::S_FD_WAIT;
      end
      lsp_pkg::S_FD_WAIT: begin
        if (div_rsp.done) begin
          state_next = (ch == 2'd2) ? lsp_pkg::S_EMIT : lsp_pkg::S_PROD_A;
        end
      end
      lsp_pkg::S_ADV: state_next = lsp_pkg::S_IDLE;
      default: state_next = lsp_pkg::S_IDLE;
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lsp_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Configuration, pattern state and output control
  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= lsp_pkg::MODE_NONE;
      interval    <= '0;
      c1          <= '0;
      c2          <= '0;
      fsteps      <= 16'd1;
      start_rev   <= 1'b0;
      pcount      <= 7'd64;
      last_ms     <= '0;
      step        <= '0;
      going_rev   <= 1'b0;
      trail_valid <= '0;
      out_valid   <= 1'b0;
    end else begin
      // Load the output register or drop the item just taken
      if (state == lsp_pkg::S_EMIT && out_free) begin
        out_valid <= 1'b1;
      end else if (result.valid && result.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        lsp_pkg::S_IDLE: begin
          if (accept) begin
            if (item.kind == lsp_pkg::KIND_REVERSE) begin
              going_rev <= !going_rev;
              step      <= going_rev ? 16'd0 : tot - 1'b1;
            end else if (due) begin
              last_ms <= item.now_ms;
            end
          end
        end
        lsp_pkg::S_SC_WAIT: trail_valid[pix] <= 1'b1;
        lsp_pkg::S_ADV:     step <= adv_step;
        default: ;
      endcase
      // Register writes arrive only while idle with no item taken
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          lsp_pkg::REG_MODE: begin
            mode <= cfg.data[2:0];
            step <= '0;
            if (cfg.data[2:0] != lsp_pkg::MODE_SCANNER) begin
              going_rev <= start_rev;
            end
          end
          lsp_pkg::REG_INTERVAL:  interval  <= cfg.data;
          lsp_pkg::REG_COLOUR1:   c1        <= cfg.data[23:0];
          lsp_pkg::REG_COLOUR2:   c2        <= cfg.data[23:0];
          lsp_pkg::REG_FADESTEPS: fsteps    <= cfg.data[15:0];
          lsp_pkg::REG_STARTREV:  start_rev <= cfg.data[0];
          lsp_pkg::REG_PIXCOUNT:  pcount    <= cfg.data[6:0];
          default: ;
        endcase
      end
    end
  end

  // Sequencer payload registers
  always_ff @(posedge clk) begin
    case (state)
      lsp_pkg::S_IDLE: begin
        ch <= '0;
        // Colour wipe puts its single pixel up front when it lands on the strip
        if (item.kind == lsp_pkg::KIND_TICK && due && mode == lsp_pkg::MODE_WIPE &&
            step < 16'(n)) begin
          upd <= 1'b1;
          pix <= step[lsp_pkg::PIX_W-1:0];
          col <= c1;
        end else begin
          upd <= 1'b0;
          pix <= '0;
          col <= '0;
        end
        if (item.kind == lsp_pkg::KIND_TICK && due) begin
          case (mode)
            lsp_pkg::MODE_RAINBOW, lsp_pkg::MODE_THEATER,
            lsp_pkg::MODE_SCANNER, lsp_pkg::MODE_FADE: begin
              single <= 1'b0;
              adv    <= 1'b1;
            end
            lsp_pkg::MODE_WIPE: begin
              single <= 1'b1;
              adv    <= 1'b1;
            end
            default: begin
              single <= 1'b1;
              adv    <= 1'b0;
            end
          endcase
        end else begin
          single <= 1'b1;
          adv    <= 1'b0;
        end
      end
      lsp_pkg::S_EMIT: begin
        if (out_free) begin
          out_upd  <= upd;
          out_pix  <= 6'(pix);
          out_rgb  <= col;
          out_last <= last_e;
          if (!last_e) begin
            pix   <= pix + 1'b1;
            phase <= (phase == 2'd2) ? 2'd0 : phase + 1'b1;
          end
        end
      end
      lsp_pkg::S_RB_WAIT: begin
        if (div_rsp.done) begin
          col <= lsp_pkg::wheel(div_rsp.quotient[7:0] + step[7:0]);
          upd <= 1'b1;
        end
      end
      lsp_pkg::S_TC_START: phase <= lsp_pkg::mod3(step);
      lsp_pkg::S_TC_PIX: begin
        col <= (phase == 2'd0) ? c1 : c2;
        upd <= 1'b1;
      end
      lsp_pkg::S_SC_RD:   rd_ok <= trail_valid[pix];
      lsp_pkg::S_SC_WAIT: begin
        col <= sc_col;
        upd <= 1'b1;
      end
      lsp_pkg::S_PROD_A:  acc <= 24'(ca) * 24'(tot - fade_k);
      lsp_pkg::S_FD_WAIT: begin
        if (div_rsp.done) begin
          ch  <= ch + 1'b1;
          upd <= 1'b1;
          case (ch)
            2'd0:    col[23:16] <= div_rsp.quotient[7:0];
            2'd1:    col[15:8]  <= div_rsp.quotient[7:0];
            default: col[7:0]   <= div_rsp.quotient[7:0];
          endcase
        end
      end
      default: ;
    endcase
  end

  // Shared divider
  lsp_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // Scanner trail store
  lsp_ram #(
    .WIDTH (24),
    .DEPTH (lsp_pkg::MAX_PIXELS)
  ) u_trail (
    .clk   (clk),
    .we    (trail_we),
    .waddr (pix),
    .wdata (sc_col),
    .re    (trail_re),
    .raddr (pix),
    .rdata (trail_rd)
  );

  // Ports
  assign item.ready     = (state == lsp_pkg::S_IDLE) && !cfg.valid;
  assign cfg.ready      = (state == lsp_pkg::S_IDLE);
  assign result.valid   = out_valid;
  assign result.updated = out_upd;
  assign result.pixel   = out_pix;
  assign result.red     = out_rgb[23:16];
  assign result.green   = out_rgb[15:8];
  assign result.blue    = out_rgb[7:0];
  assign result.last    = out_last;

  // Divider finishes only while the sequencer waits for it
  a_div_wait: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> (state == lsp_pkg::S_RB_WAIT || state == lsp_pkg::S_FD_WAIT))
    else $error("divider done outside a wait state");

  // An accepted item blocks the next one
  a_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> !item.ready)
    else $error("item taken while busy");

  // Trail writes stay on the strip
  a_trail_addr: assert property (@(posedge clk) disable iff (rst)
    trail_we |-> ({1'b0, pix} < n))
    else $error("trail write beyond pixel count");

  // Mode write restarts the index
  a_mode_restart: assert property (@(posedge clk) disable iff (rst)
    (cfg.valid && cfg.ready && cfg.index == lsp_pkg::REG_MODE) |=> (step == '0))
    else $error("step index not cleared on mode write");

endmodule
